// ----- hw/rtl/pcl_pkg.sv -----
// pcl_pkg: shared types, sizes and codes for the positional character list.
// Used by pcl_cell, pcl_chain and positional_char_list.
`default_nettype none
package pcl_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 7;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request kinds
   localparam logic [2:0] KIND_PUSH   = 3'd0;
   localparam logic [2:0] KIND_INSERT = 3'd1;
   localparam logic [2:0] KIND_READ   = 3'd2;
   localparam logic [2:0] KIND_WRITE  = 3'd3;
   localparam logic [2:0] KIND_REMOVE = 3'd4;

   // result status
   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_EMPTY  = 2'd1;
   localparam logic [1:0] STS_BADPOS = 2'd2;
   localparam logic [1:0] STS_FULL   = 2'd3;

   // cell operations
   localparam logic [2:0] OP_NOP = 3'd0;
   localparam logic [2:0] OP_INS = 3'd1;
   localparam logic [2:0] OP_RD  = 3'd2;
   localparam logic [2:0] OP_WR  = 3'd3;
   localparam logic [2:0] OP_RM  = 3'd4;

   typedef struct packed {
      logic [2:0]       kind;
      logic [POS_W-1:0] position;
      logic [7:0]       character;
   } req_type;

   typedef struct packed {
      logic [7:0] value;
      logic [1:0] status;
      logic [6:0] count;
   } rsp_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             go;
      logic [2:0]       op;
      logic [IDX_W-1:0] idx;
      logic [7:0]       ch;
   } cmd_type;

endpackage
`default_nettype wire

// ----- hw/rtl/pcl_cell.sv -----
// pcl_cell: one list slot; shifts with its neighbors on insert and remove.
// Depends on pcl_pkg.
`default_nettype none
module pcl_cell (
   input  wire                     clock,
   input  pcl_pkg::cmd_type        cmd,
   input  wire [pcl_pkg::IDX_W-1:0] cell_idx,
   input  wire [7:0]               left_val,
   input  wire [7:0]               right_val,
   output logic [7:0]              entry,
   output logic [7:0]              tap
);

   logic [7:0] entry_ff, entry_in;
   logic [7:0] tap_ff, tap_in;
   logic       hit, above;

   assign hit   = (cell_idx == cmd.idx);
   assign above = (cell_idx > cmd.idx);

   always_comb begin
      entry_in = entry_ff;
      tap_in   = tap_ff;
      if (cmd.go) begin
         tap_in = (hit && (cmd.op == pcl_pkg::OP_RD || cmd.op == pcl_pkg::OP_RM))
                  ? entry_ff : 8'h00;
         case (cmd.op)
            pcl_pkg::OP_INS: begin
               if (above) entry_in = left_val;
               else if (hit) entry_in = cmd.ch;
            end
            pcl_pkg::OP_RM: begin
               if (above || hit) entry_in = right_val;
            end
            pcl_pkg::OP_WR: begin
               // a stored zero byte is never overwritten
               if (hit && entry_ff != 8'h00) entry_in = cmd.ch;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tap_ff   <= tap_in;
   end

   assign entry = entry_ff;
   assign tap   = tap_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/pcl_chain.sv -----
// pcl_chain: row of pcl_cell slots plus the OR merge of their read taps.
// Depends on pcl_pkg and pcl_cell.
`default_nettype none
module pcl_chain (
   input  wire              clock,
   input  pcl_pkg::cmd_type cmd,
   output logic [7:0]       tap_value
);

   logic [7:0] entry_w [pcl_pkg::CAPACITY];
   logic [7:0] tap_w   [pcl_pkg::CAPACITY];

   genvar gi;
   generate
      for (gi = 0; gi < pcl_pkg::CAPACITY; gi++) begin : g_cell
         logic [7:0] left_w, right_w;
         if (gi == 0) begin : g_first
            assign left_w = 8'h00;
         end else begin : g_mid_l
            assign left_w = entry_w[gi-1];
         end
         if (gi == pcl_pkg::CAPACITY - 1) begin : g_last
            assign right_w = 8'h00;
         end else begin : g_mid_r
            assign right_w = entry_w[gi+1];
         end
         pcl_cell u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .cell_idx  (pcl_pkg::IDX_W'(gi)),
            .left_val  (left_w),
            .right_val (right_w),
            .entry     (entry_w[gi]),
            .tap       (tap_w[gi])
         );
      end
   endgenerate

   // at most one tap is nonzero
   always_comb begin
      tap_value = 8'h00;
      for (int i = 0; i < pcl_pkg::CAPACITY; i++) begin
         tap_value = tap_value | tap_w[i];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/positional_char_list.sv -----
// Usage:
//   Ordered list of bytes, addressed by one-based position, up to
//   pcl_pkg::CAPACITY entries, held in a row of cells that shift together.
//   Request channel req_*: kind (push front, insert, read, write, remove),
//   position and character. Response channel rsp_*: value, status (ok,
//   empty, invalid position or full; error responses carry 0) and count.
//   A request is taken when req_valid is high and req_stall is low; a
//   response is taken when rsp_valid is high and rsp_stall is low.
// Timing:
//   One request at a time. After acceptance it passes through S_EXEC, where
//   the cell row acts on it, and S_DONE, where the read taps are gathered
//   into the response register; the controller then returns to S_IDLE.
//   A new request is taken only in S_IDLE, so each one is through before
//   the next enters; it may enter while the previous response waits.
// Reset:
//   Synchronous, active high. Clears the count, control and valid flags;
//   cell contents are left as they are and never read past the count.
// Stall:
//   A stalled response holds in its register; the controller waits in its
//   final step and keeps req_stall high until the register frees up.
`default_nettype none
module positional_char_list (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  pcl_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output pcl_pkg::rsp_type rsp_payload
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                state_ff, state_in;
   pcl_pkg::req_type          op_ff, op_in;
   logic [pcl_pkg::CNT_W-1:0] count_ff, count_in;
   logic [1:0]                sts_ff, sts_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   pcl_pkg::rsp_type          rsp_ff, rsp_in;

   pcl_pkg::cmd_type          cmd;
   logic [7:0]                tap_value;

   logic                      req_take, rsp_free;
   logic                      is_empty, is_full, pos_ok;
   logic [pcl_pkg::POS_W-1:0] pos_m1;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == pcl_pkg::CNT_W'(pcl_pkg::CAPACITY));
   assign pos_ok   = (op_ff.position != '0) &&
                     (pcl_pkg::CMP_W'(op_ff.position) <= pcl_pkg::CMP_W'(count_ff));
   assign pos_m1   = op_ff.position - pcl_pkg::POS_W'(1);

   // decode the held request into a cell command, status and new count
   always_comb begin
      cmd.go   = (state_ff == S_EXEC);
      cmd.op   = pcl_pkg::OP_NOP;
      cmd.idx  = pcl_pkg::IDX_W'(pos_m1);
      cmd.ch   = op_ff.character;
      sts_in   = sts_ff;
      count_in = count_ff;
      if (state_ff == S_EXEC) begin
         sts_in = pcl_pkg::STS_OK;
         unique case (op_ff.kind) inside
            pcl_pkg::KIND_PUSH: begin
               if (is_full) begin
                  sts_in = pcl_pkg::STS_FULL;
               end else begin
                  cmd.op   = pcl_pkg::OP_INS;
                  cmd.idx  = '0;
                  count_in = count_ff + pcl_pkg::CNT_W'(1);
               end
            end
            pcl_pkg::KIND_INSERT: begin
               if (is_empty) sts_in = pcl_pkg::STS_EMPTY;
               else if (!pos_ok) sts_in = pcl_pkg::STS_BADPOS;
               else if (is_full) sts_in = pcl_pkg::STS_FULL;
               else begin
                  cmd.op   = pcl_pkg::OP_INS;
                  count_in = count_ff + pcl_pkg::CNT_W'(1);
               end
            end
            pcl_pkg::KIND_READ, pcl_pkg::KIND_WRITE, pcl_pkg::KIND_REMOVE: begin
               if (is_empty) sts_in = pcl_pkg::STS_EMPTY;
               else if (!pos_ok) sts_in = pcl_pkg::STS_BADPOS;
               else if (op_ff.kind == pcl_pkg::KIND_READ) cmd.op = pcl_pkg::OP_RD;
               else if (op_ff.kind == pcl_pkg::KIND_WRITE) cmd.op = pcl_pkg::OP_WR;
               else begin
                  cmd.op   = pcl_pkg::OP_RM;
                  count_in = count_ff - pcl_pkg::CNT_W'(1);
               end
            end
            default: ;  // unused kinds: no change, status ok
         endcase
      end
   end

   pcl_chain u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .tap_value (tap_value)
   );

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               rsp_in.value  = tap_value;
               rsp_in.status = sts_ff;
               rsp_in.count  = 7'(count_ff);
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      sts_ff <= sts_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pcl_pkg::CNT_W'(pcl_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_take_exec: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_EXEC)
      else $error("accepted request did not enter the cell row");

   a_full_sts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == pcl_pkg::STS_FULL |->
         rsp_ff.count == 7'(pcl_pkg::CAPACITY))
      else $error("full status with room left");

   a_empty_sts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == pcl_pkg::STS_EMPTY |->
         rsp_ff.count == 7'd0 && rsp_ff.value == 8'h00)
      else $error("empty status on a nonempty list");
`endif

endmodule
`default_nettype wire
